// ===== hdl/conjecture_candidate_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Candidate filter assertion macros
// Shared property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CONJECTURE_CANDIDATE_FILTER_UNIT_DEFINES_SVH
`define CONJECTURE_CANDIDATE_FILTER_UNIT_DEFINES_SVH

// condition holds on every edge out of reset
`define CCF_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define CCF_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCF_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ccf_pkg.sv =====
// ----------------------------------------------------------------------------
// Candidate filter package
// Sizes, codes and unit request/response types.
// ----------------------------------------------------------------------------
package ccf_pkg;

  localparam int MAX_RULES = 16;
  localparam int K_BITS    = 48;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int ROOT_W    = (K_BITS + 1) / 2;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int PROD_W    = K_BITS + ROOT_W;
  localparam int EXP_W     = $clog2(K_BITS);
  localparam int BIT_W     = $clog2(ROOT_W);
  localparam int DCNT_W    = $clog2(K_BITS);

  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 3;
  localparam int A_W     = 48;
  localparam int B_W     = 16;
  localparam int C_W     = 16;
  localparam int CAND_W  = 48;
  localparam int MATCH_W = 5;

  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TEST  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NOP   = 2'd3;

  localparam logic [KIND_W-1:0] KD_RES   = 3'd0;
  localparam logic [KIND_W-1:0] KD_POW   = 3'd1;
  localparam logic [KIND_W-1:0] KD_SSQ   = 3'd2;
  localparam logic [KIND_W-1:0] KD_XSQ   = 3'd3;
  localparam logic [KIND_W-1:0] KD_EXACT = 3'd4;

  typedef struct packed {
    logic              start;
    logic [K_BITS-1:0] num;
    logic [K_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [K_BITS-1:0] quo;
    logic [K_BITS-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [K_BITS-1:0] val;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
    logic              exact;
  } sqrt_rsp_t;

endpackage

// ===== hdl/ccf_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccf_div import ccf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [K_BITS-1:0] num;
  logic [K_BITS-1:0] den;
  logic [K_BITS-1:0] rem;
  logic [K_BITS:0]   sh;
  logic [K_BITS:0]   diff;
  logic              ge;
  logic [K_BITS-1:0] rem_next;

  assign sh       = {rem, num[K_BITS-1]};
  assign diff     = sh - {1'b0, den};
  assign ge       = sh >= {1'b0, den};
  assign rem_next = ge ? diff[K_BITS-1:0] : sh[K_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        num <= {num[K_BITS-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(K_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = num;
  assign rsp.rem  = rem;

endmodule

// ===== hdl/ccf_sqrt.sv =====
// ----------------------------------------------------------------------------
// Serial integer square root
// Digit-by-digit root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ccf_sqrt import ccf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [BIT_W-1:0]  cnt;
  logic [SQ_W-1:0]   val;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W+2:0] sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              ge;

  assign sh    = {rem, val[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = sh - trial;
  assign ge    = sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        val  <= SQ_W'(req.val);
        root <= '0;
        rem  <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[ROOT_W:0] : sh[ROOT_W:0];
        root <= {root[ROOT_W-2:0], ge};
        val  <= {val[SQ_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == BIT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.root  = root;
  assign rsp.exact = (rem == '0);

endmodule

// ===== hdl/conjecture_candidate_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Conjecture candidate filter
// Rule table plus serial arithmetic that tests candidates against the rules.
// ----------------------------------------------------------------------------
//
// channel | dir | tdata (low bit up)                 | tuser (low bit up)
// s_*     | in  | rule_a, rule_b, rule_c, candidate  | func, rule_kind
// m_*     | out | keep, matched_rule, status         | -
//
// Flow: clear and add go straight to a result word. A test walks the
//   rules in order, stopping at the first hit. Residue and both square
//   rules use the shared serial divider, the square rules also the shared
//   root unit, power rules a shift-add multiplier; exact value compares.
// Reset: rst clears the rule count and the output valid; table entries are
//   only read below the count and need no clearing.
// Stalls: one word is worked at a time; a finished result waits in the
//   output register, and the next word is taken while it waits.
//
`include "conjecture_candidate_filter_unit_defines.svh"

module conjecture_candidate_filter_unit import ccf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [47:0] rule_a, [63:48] rule_b, [79:64] rule_c, [127:80] candidate
  input  logic [127:0] s_tdata,
  // [1:0] func, [4:2] rule_kind
  input  logic [4:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] keep, [5:1] matched_rule, [6] status, [7] zero
  output logic [7:0]   m_tdata
);

  // FSM codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RULE   = 4'd1;
  localparam logic [3:0] ST_D0     = 4'd2;
  localparam logic [3:0] ST_S2     = 4'd3;
  localparam logic [3:0] ST_D2     = 4'd4;
  localparam logic [3:0] ST_D3A    = 4'd5;
  localparam logic [3:0] ST_S3     = 4'd6;
  localparam logic [3:0] ST_D3B    = 4'd7;
  localparam logic [3:0] ST_PTRY   = 4'd8;
  localparam logic [3:0] ST_PMUL   = 4'd9;
  localparam logic [3:0] ST_PCHK   = 4'd10;
  localparam logic [3:0] ST_PBIT   = 4'd11;
  localparam logic [3:0] ST_NEXT   = 4'd12;
  localparam logic [3:0] ST_RESULT = 4'd13;

  // input word fields
  logic [FUNC_W-1:0] in_func;
  logic [KIND_W-1:0] in_kind;
  logic [A_W-1:0]    in_a;
  logic [B_W-1:0]    in_b;
  logic [C_W-1:0]    in_c;
  logic [CAND_W-1:0] in_cand;

  assign in_func = s_tuser[1:0];
  assign in_kind = s_tuser[4:2];
  assign in_a    = s_tdata[47:0];
  assign in_b    = s_tdata[63:48];
  assign in_c    = s_tdata[79:64];
  assign in_cand = s_tdata[127:80];

  // rule table
  logic [KIND_W-1:0] kind_tab [MAX_RULES];
  logic [K_BITS-1:0] a_tab    [MAX_RULES];
  logic [B_W-1:0]    b_tab    [MAX_RULES];
  logic [C_W-1:0]    c_tab    [MAX_RULES];
  logic [CNT_W-1:0]  rule_count;

  logic [3:0]        st;
  logic [CNT_W-1:0]  idx;
  logic [K_BITS-1:0] k;
  logic              hit;
  logic              res_keep;
  logic [MATCH_W-1:0] res_match;
  logic              res_status;
  logic              out_keep;
  logic [MATCH_W-1:0] out_match;
  logic              out_status;

  logic [KIND_W-1:0] cur_kind;
  logic [K_BITS-1:0] cur_a;
  logic [K_BITS-1:0] cur_b;
  logic [K_BITS-1:0] cur_c;

  assign cur_kind = kind_tab[idx[IDX_W-1:0]];
  assign cur_a    = a_tab[idx[IDX_W-1:0]];
  assign cur_b    = K_BITS'(b_tab[idx[IDX_W-1:0]]);
  assign cur_c    = K_BITS'(c_tab[idx[IDX_W-1:0]]);

  // shared serial units
  logic              div_start;
  logic [K_BITS-1:0] div_num;
  logic [K_BITS-1:0] div_den;
  logic              sqrt_start;
  logic [K_BITS-1:0] sqrt_val;
  logic              div_go;
  logic              sqrt_go;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  sqrt_req_t         sqrt_req;
  sqrt_rsp_t         sqrt_rsp;

  assign div_req.start  = div_start;
  assign div_req.num    = div_num;
  assign div_req.den    = div_den;
  assign sqrt_req.start = sqrt_start;
  assign sqrt_req.val   = sqrt_val;

  // start pulses, raised on the same edge that loads the operands
  assign div_go = ((st == ST_RULE) &&
                   (((cur_kind == KD_RES) && (cur_b != '0)) ||
                    ((cur_kind == KD_XSQ) && (cur_a != '0)))) ||
                  (((st == ST_S2) || (st == ST_S3)) && sqrt_rsp.done && sqrt_rsp.exact);
  assign sqrt_go = ((st == ST_RULE) && (cur_kind == KD_SSQ) && (cur_b != '0)) ||
                   ((st == ST_D3A) && div_rsp.done && (div_rsp.rem == '0) &&
                    (cur_c != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
    end else begin
      div_start  <= div_go;
      sqrt_start <= sqrt_go;
    end
  end

  ccf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ccf_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // power search: root built MSB first, each trial raised by shift-add
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] trial;
  logic [BIT_W-1:0]  bidx;
  logic [BIT_W-1:0]  mcnt;
  logic [EXP_W-1:0]  pcnt;
  logic [PROD_W-1:0] mcand;
  logic [ROOT_W-1:0] mplier;
  logic [PROD_W-1:0] prod;
  logic              pw_eq;
  logic [ROOT_W-1:0] trial_next;

  assign trial_next = root | (ROOT_W'(1) << bidx);

  // root residue r or mod - r, the mirror only when r <= mod
  function automatic logic root_hit(input logic [K_BITS-1:0] sm,
                                    input logic [K_BITS-1:0] r,
                                    input logic [K_BITS-1:0] m);
    logic [K_BITS-1:0] mir;
    mir = m - r;
    return (sm == r) || ((r <= m) && (sm == mir));
  endfunction

  assign s_tready = (st == ST_IDLE);
  assign m_tdata  = {1'b0, out_status, out_match, out_keep};

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      rule_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // drained word; a reload in ST_RESULT takes its place
      if (m_tvalid && m_tready && (st != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            res_keep   <= (in_func == FN_TEST) && (rule_count == '0);
            res_match  <= MATCH_W'(MAX_RULES);
            res_status <= (in_func == FN_ADD) && (rule_count >= CNT_W'(MAX_RULES));
            k          <= K_BITS'(in_cand);
            idx        <= '0;
            case (in_func)
              FN_CLEAR: begin
                rule_count <= '0;
                st         <= ST_RESULT;
              end
              FN_ADD: begin
                if (rule_count < CNT_W'(MAX_RULES)) begin
                  kind_tab[rule_count[IDX_W-1:0]] <= in_kind;
                  a_tab[rule_count[IDX_W-1:0]]    <= K_BITS'(in_a);
                  b_tab[rule_count[IDX_W-1:0]]    <= in_b;
                  c_tab[rule_count[IDX_W-1:0]]    <= in_c;
                  rule_count <= rule_count + 1'b1;
                end
                st <= ST_RESULT;
              end
              FN_TEST: begin
                if (rule_count == '0) begin
                  st <= ST_RESULT;
                end else begin
                  st <= ST_RULE;
                end
              end
              default: st <= ST_RESULT;
            endcase
          end
        end
        ST_RULE: begin
          case (cur_kind)
            KD_RES: begin
              if (cur_b == '0) begin
                hit <= 1'b0;
                st  <= ST_NEXT;
              end else begin
                div_num <= k;
                div_den <= cur_b;
                st      <= ST_D0;
              end
            end
            KD_POW: begin
              if (cur_a == '0) begin
                hit <= 1'b0;
                st  <= ST_NEXT;
              end else if (k <= K_BITS'(1) || cur_a == K_BITS'(1)) begin
                hit <= 1'b1;
                st  <= ST_NEXT;
              end else if (cur_a >= K_BITS'(K_BITS)) begin
                // k >= 2 needs a root >= 2, so 2^p already exceeds k
                hit <= 1'b0;
                st  <= ST_NEXT;
              end else begin
                root  <= '0;
                bidx  <= BIT_W'(ROOT_W - 1);
                pw_eq <= 1'b0;
                st    <= ST_PTRY;
              end
            end
            KD_SSQ: begin
              if (cur_b == '0) begin
                hit <= 1'b0;
                st  <= ST_NEXT;
              end else begin
                sqrt_val <= k;
                st       <= ST_S2;
              end
            end
            KD_XSQ: begin
              if (cur_a == '0) begin
                hit <= 1'b0;
                st  <= ST_NEXT;
              end else begin
                div_num <= k;
                div_den <= cur_a;
                st      <= ST_D3A;
              end
            end
            KD_EXACT: begin
              hit <= (k == cur_a);
              st  <= ST_NEXT;
            end
            default: begin
              hit <= 1'b0;
              st  <= ST_NEXT;
            end
          endcase
        end
        ST_D0: begin
          if (div_rsp.done) begin
            hit <= (div_rsp.rem == cur_a);
            st  <= ST_NEXT;
          end
        end
        ST_S2: begin
          if (sqrt_rsp.done) begin
            if (!sqrt_rsp.exact) begin
              hit <= 1'b0;
              st  <= ST_NEXT;
            end else begin
              div_num <= K_BITS'(sqrt_rsp.root);
              div_den <= cur_b;
              st      <= ST_D2;
            end
          end
        end
        ST_D2: begin
          if (div_rsp.done) begin
            hit <= root_hit(div_rsp.rem, cur_a, cur_b);
            st  <= ST_NEXT;
          end
        end
        ST_D3A: begin
          if (div_rsp.done) begin
            if (div_rsp.rem != '0 || cur_c == '0) begin
              hit <= 1'b0;
              st  <= ST_NEXT;
            end else begin
              sqrt_val <= div_rsp.quo;
              st       <= ST_S3;
            end
          end
        end
        ST_S3: begin
          if (sqrt_rsp.done) begin
            if (!sqrt_rsp.exact) begin
              hit <= 1'b0;
              st  <= ST_NEXT;
            end else begin
              div_num <= K_BITS'(sqrt_rsp.root);
              div_den <= cur_c;
              st      <= ST_D3B;
            end
          end
        end
        ST_D3B: begin
          if (div_rsp.done) begin
            hit <= root_hit(div_rsp.rem, cur_b, cur_c);
            st  <= ST_NEXT;
          end
        end
        ST_PTRY: begin
          trial  <= trial_next;
          mcand  <= PROD_W'(1);
          mplier <= trial_next;
          prod   <= '0;
          mcnt   <= '0;
          pcnt   <= '0;
          st     <= ST_PMUL;
        end
        ST_PMUL: begin
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand  <= {mcand[PROD_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[ROOT_W-1:1]};
          mcnt   <= mcnt + 1'b1;
          if (mcnt == BIT_W'(ROOT_W - 1)) begin
            st <= ST_PCHK;
          end
        end
        ST_PCHK: begin
          // trial^(pcnt+1) is in prod; stop early once it passes k
          if (prod > PROD_W'(k)) begin
            st <= ST_PBIT;
          end else if (EXP_W'(pcnt + 1'b1) == cur_a[EXP_W-1:0]) begin
            root  <= trial;
            pw_eq <= (prod == PROD_W'(k));
            st    <= ST_PBIT;
          end else begin
            pcnt   <= pcnt + 1'b1;
            mcand  <= prod;
            mplier <= trial;
            prod   <= '0;
            mcnt   <= '0;
            st     <= ST_PMUL;
          end
        end
        ST_PBIT: begin
          if (bidx == '0) begin
            hit <= pw_eq;
            st  <= ST_NEXT;
          end else begin
            bidx <= bidx - 1'b1;
            st   <= ST_PTRY;
          end
        end
        ST_NEXT: begin
          if (hit) begin
            res_match <= MATCH_W'(idx);
            st        <= ST_RESULT;
          end else if (idx + 1'b1 == rule_count) begin
            res_keep <= 1'b1;
            st       <= ST_RESULT;
          end else begin
            idx <= idx + 1'b1;
            st  <= ST_RULE;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_keep   <= res_keep;
            out_match  <= res_match;
            out_status <= res_status;
            st         <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  `CCF_CHECK(a_count_bound, rule_count <= CNT_W'(MAX_RULES), "rule count beyond table")
  `CCF_IMPLY(a_idx_range, st == ST_RULE, idx < rule_count, "rule index past count")
  `CCF_IMPLY(a_keep_none, m_tvalid && out_keep, out_match == MATCH_W'(MAX_RULES) && !out_status, "kept word with a match")
  `CCF_NEXT(a_result_load, st == ST_RESULT && (!m_tvalid || m_tready), m_tvalid && st == ST_IDLE, "result not loaded")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Candidate filter testbench
// Drives clear, add, test and unused-code words through the stream ports with random
// gaps and stalls. A local rule table predicts each result word, and the
// monitor checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ccf_pkg::*;

  typedef longint unsigned u64;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KIND_W-1:0] kind;
    logic [A_W-1:0]    a;
    logic [B_W-1:0]    b;
    logic [C_W-1:0]    c;
    logic [CAND_W-1:0] cand;
  } word_t;

  typedef struct {
    logic               keep;
    logic [MATCH_W-1:0] rule;
    logic               status;
  } verdict_t;

  localparam u64 KMASK = (u64'(1) << K_BITS) - 1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [4:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  word_t    pending[$];
  verdict_t verdicts[$];
  int       total_words;
  int       n_taken = 0;
  int       n_fail = 0;
  int       send_gap = 35;
  int       recv_gap = 61;
  int       hold_cnt = 0;
  bit       held = 1'b0;

  // predictor copy of the rule table
  logic [KIND_W-1:0] p_kind[MAX_RULES];
  u64                p_a[MAX_RULES];
  u64                p_b[MAX_RULES];
  u64                p_c[MAX_RULES];
  int                p_count = 0;

  // generator shadow, tracks what has been queued
  logic [KIND_W-1:0] g_kind[MAX_RULES];
  u64                g_a[MAX_RULES];
  u64                g_b[MAX_RULES];
  u64                g_c[MAX_RULES];
  int                g_count = 0;

  conjecture_candidate_filter_unit dut (.*);

  always #5 clk = ~clk;

  function automatic u64 int_sqrt(u64 v);
    u64 res, bitv;
    res = 0;
    bitv = u64'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // -1 when r^p < k, 0 equal, 1 above
  function automatic int pow_order(u64 r, u64 p, u64 k);
    u64 acc;
    acc = 1;
    for (u64 i = 0; i < p; i++) begin
      if (acc > k / r) return 1;
      acc *= r;
    end
    return acc < k ? -1 : (acc == k ? 0 : 1);
  endfunction

  function automatic bit perfect_power(u64 k, u64 p);
    u64 lo, hi, mid;
    int o;
    if (p == 0) return 0;
    if (k <= 1 || p == 1) return 1;
    if (p >= 64) return 0;
    lo = 2;
    hi = k < 64'hFFFF_FFFF ? k : 64'hFFFF_FFFF;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      o = pow_order(mid, p, k);
      if (o == 0) return 1;
      if (o < 0) lo = mid + 1;
      else hi = mid - 1;
    end
    return 0;
  endfunction

  function automatic bit root_fits(u64 v, u64 res, u64 md);
    u64 s, sm;
    if (md == 0) return 0;
    s = int_sqrt(v);
    if (s * s != v) return 0;
    sm = s % md;
    return sm == res || (res <= md && sm == md - res);
  endfunction

  function automatic bit rule_hits(int i, u64 k);
    case (p_kind[i])
      KD_RES:   return p_b[i] != 0 && k % p_b[i] == p_a[i];
      KD_POW:   return perfect_power(k, p_a[i]);
      KD_SSQ:   return root_fits(k, p_a[i], p_b[i]);
      KD_XSQ:   return p_a[i] != 0 && k % p_a[i] == 0 && root_fits(k / p_a[i], p_b[i], p_c[i]);
      KD_EXACT: return k == p_a[i];
      default:  return 0;
    endcase
  endfunction

  function automatic verdict_t filter_verdict(word_t w);
    verdict_t v;
    u64 k;
    v = '{keep: 1'b0, rule: MATCH_W'(MAX_RULES), status: 1'b0};
    if (w.func == FN_CLEAR) begin
      p_count = 0;
    end else if (w.func == FN_ADD) begin
      if (p_count >= MAX_RULES) begin
        v.status = 1'b1;
      end else begin
        p_kind[p_count] = w.kind;
        p_a[p_count] = u64'(w.a) & KMASK;
        p_b[p_count] = w.b;
        p_c[p_count] = w.c;
        p_count++;
      end
    end else if (w.func == FN_TEST) begin
      k = u64'(w.cand) & KMASK;
      v.keep = 1'b1;
      for (int i = 0; i < p_count; i++) begin
        if (rule_hits(i, k)) begin
          v.keep = 1'b0;
          v.rule = MATCH_W'(i);
          break;
        end
      end
    end
    return v;
  endfunction

  // ---------------- stimulus builders ----------------
  task automatic push_clear();
    word_t w;
    w = '{func: FN_CLEAR, kind: 3'($urandom), a: {$urandom, $urandom},
          b: 16'($urandom), c: 16'($urandom), cand: {$urandom, $urandom}};
    pending.insert(pending.size(), w);
    g_count = 0;
  endtask

  task automatic push_rule(logic [KIND_W-1:0] kd, u64 a, u64 b, u64 c);
    word_t w;
    w = '{func: FN_ADD, kind: kd, a: A_W'(a), b: B_W'(b), c: C_W'(c),
          cand: {$urandom, $urandom}};
    pending.insert(pending.size(), w);
    if (g_count < MAX_RULES) begin
      g_kind[g_count] = kd;
      g_a[g_count] = a & KMASK;
      g_b[g_count] = b & 16'hFFFF;
      g_c[g_count] = c & 16'hFFFF;
      g_count++;
    end
  endtask

  task automatic push_probe(u64 k);
    word_t w;
    w = '{func: FN_TEST, kind: 3'($urandom), a: {$urandom, $urandom},
          b: 16'($urandom), c: 16'($urandom), cand: CAND_W'(k)};
    pending.insert(pending.size(), w);
  endtask

  // candidate aimed at rule i; falls back to a random value
  function automatic u64 aim_at(int i);
    u64 s, k, r, p;
    k = {$urandom, $urandom} & KMASK;
    case (g_kind[i])
      KD_RES: if (g_b[i] != 0) k = g_a[i] + g_b[i] * $urandom_range(0, 100000);
      KD_POW: begin
        p = g_a[i];
        if (p >= 1 && p < 48) begin
          r = $urandom_range(0, p == 1 ? 1000 : (p <= 3 ? 3000 : 40));
          s = 1;
          for (u64 j = 0; j < p && s <= KMASK; j++) s *= r;
          if (s <= KMASK) k = s;
        end
      end
      KD_SSQ: if (g_b[i] != 0) begin
        s = g_b[i] * $urandom_range(0, 200) +
            ($urandom_range(1) ? g_a[i] : g_b[i] - g_a[i]);
        if (s < (1 << 24)) k = s * s;
      end
      KD_XSQ: if (g_c[i] != 0 && g_a[i] != 0) begin
        s = g_c[i] * $urandom_range(0, 20) +
            ($urandom_range(1) ? g_b[i] : g_c[i] - g_b[i]);
        if (s < (1 << 24) && s * s <= KMASK / g_a[i]) k = g_a[i] * s * s;
      end
      KD_EXACT: k = g_a[i];
      default: ;
    endcase
    return k & KMASK;
  endfunction

  task automatic push_random_rule(inout int n_pow);
    int sel;
    u64 m;
    sel = $urandom_range(0, 99);
    m = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, $urandom_range(1) ? 60 : 65535);
    if (sel < 22)
      push_rule(KD_RES, $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : m / 2, m, $urandom);
    else if (sel < 34 && n_pow < 2) begin
      n_pow++;
      push_rule(KD_POW, $urandom_range(0, 20) == 0 ? $urandom_range(7, 70)
                : $urandom_range(0, 6), $urandom, $urandom);
    end else if (sel < 54)
      push_rule(KD_SSQ, $urandom_range(0, 5) == 0 ? m + 3 : m / 3, m, $urandom);
    else if (sel < 74)
      push_rule(KD_XSQ, $urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 999),
                m / 4, m);
    else if (sel < 94)
      push_rule(KD_EXACT, {$urandom, $urandom}, $urandom, $urandom);
    else
      push_rule(3'($urandom_range(5, 7)), {$urandom, $urandom}, $urandom, $urandom);
  endtask

  task automatic build_stimulus();
    int n_rules, n_tests, n_pow;
    word_t w;
    // directed part
    push_probe(0);                                // empty table keeps everything
    push_rule(KD_RES, 3, 0, 0);                   // zero modulus never matches
    push_rule(KD_POW, 0, 0, 0);                   // exponent zero never matches
    push_rule(KD_XSQ, 0, 1, 5);                   // zero multiplier
    push_rule(3'd7, {$urandom, $urandom}, 16'hFFFF, 16'hFFFF); // unknown kind
    push_rule(KD_SSQ, 9, 7, 0);                   // root residue above modulus
    push_rule(KD_EXACT, KMASK, 16'hFFFF, 16'hFFFF);
    push_probe(49);                               // root 7 mod 7 = 0, no hit
    push_probe(81);                               // root 9 mod 7 = 2, no hit
    push_probe(KMASK);                            // exact max
    push_rule(KD_XSQ, 3, 2, 5);
    push_probe(3 * 64);                           // 3*8^2, 8 mod 5 = 3 = 5-2
    push_probe(3 * 64 + 1);
    push_rule(KD_POW, 3, 0, 0);
    push_probe(1);                                // one is every power
    push_probe(u64'(1000003) * 1000003 * 100);
    push_probe(u64'(12345) * 12345 * 12345);
    push_rule(KD_POW, 1, 0, 0);
    push_probe(KMASK - 1);                        // exponent one hits all
    for (int i = 0; i < 6; i++) push_rule(KD_RES, 0, 16'h8000, 0);
    push_rule(KD_EXACT, 5, 0, 0);                 // table full here
    w = '{func: FN_NOP, kind: 3'h7, a: '1, b: '1, c: '1, cand: '1};
    pending.insert(pending.size(), w);            // unused function code
    push_clear();
    // random part: mostly well-formed clear, load, test sequences
    while (pending.size() < 1950) begin
      if ($urandom_range(0, 3) != 0) push_clear();
      n_pow = 0;
      for (int i = 0; i < g_count; i++) if (g_kind[i] == KD_POW) n_pow++;
      n_rules = $urandom_range(0, 9) == 0 ? $urandom_range(12, 18) : $urandom_range(1, 6);
      for (int i = 0; i < n_rules; i++) push_random_rule(n_pow);
      n_tests = $urandom_range(3, 14);
      for (int i = 0; i < n_tests; i++) begin
        if (g_count != 0 && $urandom_range(0, 2) != 0)
          push_probe(aim_at($urandom_range(0, g_count - 1)));
        else
          push_probe($urandom_range(0, 3) == 0 ? $urandom_range(0, 300)
                     : {$urandom, $urandom} & KMASK);
      end
      if ($urandom_range(0, 30) == 0) begin
        w = '{func: FN_NOP, kind: 3'($urandom), a: {$urandom, $urandom},
              b: 16'($urandom), c: 16'($urandom), cand: {$urandom, $urandom}};
        pending.insert(pending.size(), w);
      end
    end
    total_words = pending.size();
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending.size() != 0 && $urandom_range(0, 99) >= send_gap) begin
        s_tdata  <= {pending[0].cand, pending[0].c, pending[0].b, pending[0].a};
        s_tuser  <= {pending[0].kind, pending[0].func};
        s_tvalid <= 1'b1;
        void'(pending.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // accepted input words feed the predictor
  always @(posedge clk) begin
    word_t w;
    if (!rst && s_tvalid && s_tready) begin
      w.func = s_tuser[1:0];
      w.kind = s_tuser[4:2];
      w.a    = s_tdata[47:0];
      w.b    = s_tdata[63:48];
      w.c    = s_tdata[79:64];
      w.cand = s_tdata[127:80];
      verdicts.insert(verdicts.size(), filter_verdict(w));
      n_taken++;
      if (n_taken >= 2 * total_words / 3) begin
        send_gap = 0;
        recv_gap = 0;
      end else if (n_taken >= total_words / 3) begin
        send_gap = 61;
        recv_gap = 35;
      end
    end
  end

  // receiver, with one long hold-off once the last phase starts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!held && n_taken >= 2 * total_words / 3) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 3000) held <= 1'b1;
    end else begin
      m_tready <= $urandom_range(0, 99) >= recv_gap;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        n_fail++;
      end else begin
        v = verdicts.pop_front();
        if (m_tdata[0] !== v.keep) begin
          $error("keep: expected %0d got %0d", v.keep, m_tdata[0]);
          n_fail++;
        end
        if (m_tdata[5:1] !== v.rule) begin
          $error("matched_rule: expected %0d got %0d", v.rule, m_tdata[5:1]);
          n_fail++;
        end
        if (m_tdata[6] !== v.status) begin
          $error("status: expected %0d got %0d", v.status, m_tdata[6]);
          n_fail++;
        end
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (n_taken == total_words && verdicts.size() == 0);
    repeat (200) @(posedge clk);
    if (n_fail == 0 && verdicts.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #2_000_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ccf_pkg.sv
hdl/ccf_div.sv
hdl/ccf_sqrt.sv
hdl/conjecture_candidate_filter_unit.sv
test/testbench.sv
